// ----- hdl/ssoc_pkg.sv -----
// Shared constants and controller/datapath interface types for the span overlap checker.
`timescale 1ns / 1ps
`default_nettype none
package ssoc_pkg;

	localparam int MAX_SEG = 1024;
	localparam int IDX_W = $clog2(MAX_SEG);
	localparam int CNT_W = IDX_W + 1;

	localparam logic [1:0] CFG_FILE_SIZE = 2'd0;
	localparam logic [1:0] CFG_SECTOR_SHIFT = 2'd1;
	localparam logic [1:0] CFG_METADATA_END = 2'd2;

	typedef struct packed {
		logic accept;
		logic calc;
		logic commit;
		logic set_i;
		logic inc_i;
		logic clr_j;
		logic inc_j;
		logic rd_en;
		logic rd_sel_j;
		logic lat_cur;
		logic res_load;
		logic res_val;
		logic tbl_clr;
	} ssoc_cmd_t;

	typedef struct packed {
		logic bad;
		logic last;
		logic few;
		logic j_last;
		logic i_last;
		logic overlap;
	} ssoc_sts_t;

endpackage
`default_nettype wire

// ----- hdl/ssoc_dp.sv -----
// Datapath: configuration registers, record check pipeline, span memory and pair compare.
`timescale 1ns / 1ps
`default_nettype none
module ssoc_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic [15:0]          sector,
	input  wire logic [15:0]          seg_length,
	input  wire logic                 has_relocations,
	input  wire logic [15:0]          relocation_count,
	input  wire logic                 last,
	input  wire ssoc_pkg::ssoc_cmd_t  cmd,
	output ssoc_pkg::ssoc_sts_t       sts,
	output logic                      status
);
	import ssoc_pkg::*;

	logic [31:0] fs_q;
	logic [4:0]  sh_q;
	logic [31:0] me_q;

	logic [46:0] lo_s1;
	logic [16:0] len_s1;
	logic        rel_s1;
	logic [15:0] rc_s1;
	logic        zero_s1;
	logic        last_s1;

	logic [47:0] hi_s2;
	logic [19:0] tail_s2;
	logic        lo_bad_s2;
	logic [31:0] lo_s2;

	logic [CNT_W-1:0] count_q;
	logic             bad_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;

	logic [63:0] mem_q [MAX_SEG];
	logic [63:0] rd_q;
	logic [31:0] cur_s_q;
	logic [31:0] cur_e_q;
	logic        status_q;

	logic [48:0] full;
	logic        fit_bad;
	logic        store_full;
	logic        wr_ok;
	logic        rec_bad;

	assign full       = {1'b0, hi_s2} + {29'd0, tail_s2};
	assign fit_bad    = full > {17'd0, fs_q};
	assign store_full = count_q == CNT_W'(MAX_SEG);
	assign rec_bad    = zero_s1 ? rel_s1 : (lo_bad_s2 | fit_bad | store_full);
	assign wr_ok      = cmd.commit && !bad_q && !zero_s1 && !rec_bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q    <= 32'd0;
			sh_q    <= 5'd9;
			me_q    <= 32'd64;
			count_q <= '0;
			bad_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FILE_SIZE:    fs_q <= cfg_data;
					CFG_SECTOR_SHIFT: sh_q <= cfg_data[4:0];
					CFG_METADATA_END: me_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.tbl_clr) begin
				count_q <= '0;
				bad_q   <= 1'b0;
			end else if (cmd.commit && !bad_q) begin
				if (rec_bad)
					bad_q <= 1'b1;
				else if (!zero_s1)
					count_q <= count_q + CNT_W'(1);
			end
			if (cmd.set_i)
				i_q <= IDX_W'(1);
			else if (cmd.inc_i)
				i_q <= i_q + IDX_W'(1);
			if (cmd.clr_j)
				j_q <= '0;
			else if (cmd.inc_j)
				j_q <= j_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			lo_s1   <= {31'd0, sector} << sh_q;
			len_s1  <= (seg_length == 16'd0) ? 17'h10000 : {1'b0, seg_length};
			rel_s1  <= has_relocations;
			rc_s1   <= relocation_count;
			zero_s1 <= sector == 16'd0;
			last_s1 <= last;
		end
		if (cmd.calc) begin
			hi_s2     <= {1'b0, lo_s1} + {31'd0, len_s1};
			tail_s2   <= rel_s1 ? (20'd2 + {1'b0, rc_s1, 3'b000}) : 20'd0;
			lo_bad_s2 <= lo_s1 < {15'd0, me_q};
			lo_s2     <= lo_s1[31:0];
		end
		if (cmd.res_load)
			status_q <= cmd.res_val;
		if (cmd.lat_cur) begin
			cur_s_q <= rd_q[63:32];
			cur_e_q <= rd_q[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok)
			mem_q[count_q[IDX_W-1:0]] <= {lo_s2, full[31:0]};
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en)
			rd_q <= mem_q[cmd.rd_sel_j ? j_q : i_q];
	end

	always_comb begin
		sts.bad     = bad_q;
		sts.last    = last_s1;
		sts.few     = count_q < CNT_W'(2);
		sts.j_last  = (j_q + IDX_W'(1)) == i_q;
		sts.i_last  = ({1'b0, i_q} + CNT_W'(1)) == count_q;
		sts.overlap = (rd_q[63:32] < cur_e_q) && (cur_s_q < rd_q[31:0]);
	end

	assign status = status_q;

endmodule
`default_nettype wire

// ----- hdl/ssoc_ctrl.sv -----
// Controller: sequences record checks, the pairwise overlap sweep and the result handshake.
`timescale 1ns / 1ps
`default_nettype none
module ssoc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  wire logic                out_stall,
	input  wire ssoc_pkg::ssoc_sts_t sts,
	output ssoc_pkg::ssoc_cmd_t      cmd
);
	import ssoc_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CALC = 4'd1;
	localparam logic [3:0] ST_COMMIT = 4'd2;
	localparam logic [3:0] ST_EVAL = 4'd3;
	localparam logic [3:0] ST_RDC = 4'd4;
	localparam logic [3:0] ST_LATC = 4'd5;
	localparam logic [3:0] ST_RDJ = 4'd6;
	localparam logic [3:0] ST_CMP = 4'd7;
	localparam logic [3:0] ST_RESULT = 4'd8;

	logic [3:0] state_q, state_d;
	logic       pend_q, pend_d;
	logic       valid_q;
	logic       slot_free;

	assign slot_free = !valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid)
					state_d = ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = sts.last ? ST_EVAL : ST_IDLE;
			end
			ST_EVAL: begin
				if (sts.bad) begin
					pend_d  = 1'b1;
					state_d = ST_RESULT;
				end else if (sts.few) begin
					pend_d  = 1'b0;
					state_d = ST_RESULT;
				end else begin
					cmd.set_i = 1'b1;
					state_d   = ST_RDC;
				end
			end
			ST_RDC: begin
				cmd.rd_en = 1'b1;
				cmd.clr_j = 1'b1;
				state_d   = ST_LATC;
			end
			ST_LATC: begin
				cmd.lat_cur = 1'b1;
				state_d     = ST_RDJ;
			end
			ST_RDJ: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_sel_j = 1'b1;
				state_d      = ST_CMP;
			end
			ST_CMP: begin
				if (sts.overlap) begin
					pend_d  = 1'b1;
					state_d = ST_RESULT;
				end else if (sts.j_last) begin
					if (sts.i_last) begin
						pend_d  = 1'b0;
						state_d = ST_RESULT;
					end else begin
						cmd.inc_i = 1'b1;
						state_d   = ST_RDC;
					end
				end else begin
					cmd.inc_j = 1'b1;
					state_d   = ST_RDJ;
				end
			end
			ST_RESULT: begin
				if (slot_free) begin
					cmd.res_load = 1'b1;
					cmd.res_val  = pend_q;
					cmd.tbl_clr  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			if (cmd.res_load)
				valid_q <= 1'b1;
			else if (!out_stall)
				valid_q <= 1'b0;
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = valid_q;

endmodule
`default_nettype wire

// ----- hdl/segment_span_overlap_check.sv -----
// Top level of the segment span overlap checker.
//
//   channel | direction | handshake          | payload
//   config  | in        | cfg_we             | cfg_index, cfg_data
//   record  | in        | in_valid/in_stall  | sector, seg_length, has_relocations,
//           |           |                    | relocation_count, last
//   result  | out       | out_valid/out_stall| status
//
// Each record item passes capture and shift, length and tail sums, then the bound
// compare and the write into the span memory, before the next record is taken.
// On the item marked last, unless a record failed its check, every stored span is
// compared with each earlier one, one pair at a time on the single memory read port;
// the sweep stops at the first overlap found.
// Reset clears the control state and the span count; the span memory is not cleared.
// A result waiting on out_stall does not hold up the following records; only the
// next table's result waits for the output register to empty.
`timescale 1ns / 1ps
`default_nettype none
module segment_span_overlap_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] sector,
	input  wire logic [15:0] seg_length,
	input  wire logic        has_relocations,
	input  wire logic [15:0] relocation_count,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status
);
	import ssoc_pkg::*;

	// Commands flow from the controller to the datapath, status flows back.
	ssoc_cmd_t cmd;
	ssoc_sts_t sts;

	ssoc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ssoc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.sector           (sector),
		.seg_length       (seg_length),
		.has_relocations  (has_relocations),
		.relocation_count (relocation_count),
		.last             (last),
		.cmd              (cmd),
		.sts              (sts),
		.status           (status)
	);

endmodule
`default_nettype wire

// ----- hdl/ssoc_checker.sv -----
// Port-level checker for the span overlap checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ssoc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic last,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic status
);

	// A result item that is held back keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("result item changed while stalled");

	// Every accepted record keeps the block busy for the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("record accepted on consecutive cycles");

	// A record that does not close the table gives no result.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last |=> !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result after a record that was not last");

	// A new result comes out only as the block returns to taking records.
	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result raised while still busy");

endmodule

bind segment_span_overlap_check ssoc_checker u_ssoc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.last      (last),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status)
);
`default_nettype wire
